/* rtl/mbrf_pkg.sv */
// shared constants, command and status codes for the modbus register file
`default_nettype none
package mbrf_pkg;

    localparam int NUM_REGS   = 32;
    localparam int WIDE_START = 16;
    localparam int ADDR_W     = $clog2(NUM_REGS);
    localparam int ROWS       = NUM_REGS / 2;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int WORD_W     = 16;
    localparam int ENTRY_W    = WORD_W + 1;
    localparam int CMD_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_COIL   = 4'd0,
        CMD_WR_WORD   = 4'd1,
        CMD_WR_LONG   = 4'd2,
        CMD_RD_COIL   = 4'd3,
        CMD_RD_WORD   = 4'd4,
        CMD_RD_LONG   = 4'd5,
        CMD_INIT_WORD = 4'd6,
        CMD_INIT_LONG = 4'd7,
        CMD_CLEAR     = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BOUND = 2'd1,
        ST_NO_ADDR   = 2'd2,
        ST_SEQ_ERR   = 2'd3
    } status_t;

    localparam logic CFG_COIL_MASK    = 1'b0;
    localparam logic CFG_HOLDING_MASK = 1'b1;

endpackage
`default_nettype wire

/* rtl/modbus_register_file.sv */
// top level of the modbus register file: banked word/coil memory with flag registers
// a request is latched together with its bank read; in S_EXEC its result is loaded into the
//   output register once that register is free or being taken, and m_tvalid rises with it
// no new request is accepted until the previous result is loaded, since each request takes a
//   read-then-write pass on the banks; a waiting result in the output register holds it off
// reset: rst_n clears flags, bind masks, low-word latch, entry valid bits and handshake
//   state at once; memory contents read as zero until an entry is first written
`default_nettype none
module modbus_register_file (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [mbrf_pkg::IN_W-1:0]  s_tdata,  // cmd[3:0], address[8:4], write_data[40:9]
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [mbrf_pkg::OUT_W-1:0]      m_tdata,  // status[1:0], read_data[33:2],
                                                      // reg_changed[34], reg_inited[35],
                                                      // any_changed[36], pending_init[68:37]
    // configuration writes
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [31:0]                cfg_wdata
);
    import mbrf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // word i and coil i share one entry {coil, word}; even indexes live in the
    // even bank, odd in the odd bank, so words a and a+1 are read in parallel
    logic [ENTRY_W-1:0] even_mem [ROWS];
    logic [ENTRY_W-1:0] odd_mem  [ROWS];
    logic [ENTRY_W-1:0] even_rd_reg, odd_rd_reg;

    state_t state_reg, state_next;

    logic [31:0] coil_mask_reg, holding_mask_reg;

    // flags, one bit per register
    logic [NUM_REGS-1:0] vld_reg, vld_next;
    logic [NUM_REGS-1:0] ccf_reg, ccf_next;
    logic [NUM_REGS-1:0] hcf_reg, hcf_next;
    logic [NUM_REGS-1:0] init_reg, init_next;

    // emulated 32-bit write latch
    logic              low_pend_reg, low_pend_next;
    logic [WORD_W-1:0] low_word_reg, low_word_next;
    logic [ADDR_W-1:0] low_addr_reg, low_addr_next;

    // latched request
    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [31:0]       wdata_reg;

    // output register
    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    logic s_fire, exec_fire;

    // request decode on the input side
    logic [ADDR_W-1:0] in_addr;
    logic [ROW_W-1:0]  even_rrow, odd_rrow;

    assign in_addr  = s_tdata[CMD_W +: ADDR_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign exec_fire = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    // word a+1 of an odd a sits one row further on in the even bank
    assign odd_rrow  = in_addr[ADDR_W-1:1];
    assign even_rrow = in_addr[0] ? ROW_W'(in_addr[ADDR_W-1:1] + 1'b1) : in_addr[ADDR_W-1:1];

    // execution stage signals
    logic [ADDR_W:0]    a_ext, b_ext;
    logic [ADDR_W-1:0]  a_idx, b_idx;
    logic               long_ok, word_ok;
    logic [ENTRY_W-1:0] ent_a, ent_b;
    logic               wr_a, wr_b;
    logic [ENTRY_W-1:0] new_a, new_b;
    status_t            status;
    logic [31:0]        rd_data;
    logic               kind_coil, kind_word, kind_long;
    logic               changed, inited, any_chg;

    logic               even_we, odd_we;
    logic [ROW_W-1:0]   even_wrow, odd_wrow;
    logic [ENTRY_W-1:0] even_wdata, odd_wdata;

    always_comb
    begin
        a_ext   = {1'b0, addr_reg};
        b_ext   = a_ext + 1'b1;
        a_idx   = addr_reg;
        b_idx   = b_ext[ADDR_W-1:0];
        word_ok = a_ext < (ADDR_W+1)'(NUM_REGS);
        long_ok = b_ext < (ADDR_W+1)'(NUM_REGS);

        // entries never written read as zero
        ent_a = addr_reg[0] ? odd_rd_reg : even_rd_reg;
        ent_b = addr_reg[0] ? even_rd_reg : odd_rd_reg;
        if (!vld_reg[a_idx])
        begin
            ent_a = '0;
        end
        if (!long_ok || !vld_reg[b_idx])
        begin
            ent_b = '0;
        end

        vld_next      = vld_reg;
        ccf_next      = ccf_reg;
        hcf_next      = hcf_reg;
        init_next     = init_reg;
        low_pend_next = low_pend_reg;
        low_word_next = low_word_reg;
        low_addr_next = low_addr_reg;
        wr_a          = 1'b0;
        wr_b          = 1'b0;
        new_a         = ent_a;
        new_b         = ent_b;
        status        = ST_OK;
        rd_data       = '0;
        kind_coil     = 1'b0;
        kind_word     = 1'b0;
        kind_long     = 1'b0;

        unique case (cmd_reg)
            CMD_WR_COIL:
            begin
                kind_coil = 1'b1;
                if (word_ok && coil_mask_reg[a_idx])
                begin
                    if (ent_a[WORD_W] != wdata_reg[0])
                    begin
                        wr_a            = 1'b1;
                        new_a[WORD_W]   = wdata_reg[0];
                        ccf_next[a_idx] = 1'b1;
                    end
                end
                else
                begin
                    status = ST_NOT_BOUND;
                end
            end
            CMD_WR_WORD:
            begin
                kind_word = 1'b1;
                if (a_ext < (ADDR_W+1)'(WIDE_START))
                begin
                    if (word_ok && holding_mask_reg[a_idx])
                    begin
                        if (ent_a[WORD_W-1:0] != wdata_reg[WORD_W-1:0])
                        begin
                            wr_a               = 1'b1;
                            new_a[WORD_W-1:0]  = wdata_reg[WORD_W-1:0];
                            hcf_next[a_idx]    = 1'b1;
                            init_next[a_idx]   = 1'b0;
                        end
                    end
                    else
                    begin
                        status = ST_NOT_BOUND;
                    end
                end
                else if (!(long_ok && holding_mask_reg[a_idx]))
                begin
                    status = ST_NO_ADDR;
                end
                else if (addr_reg[0])
                begin
                    // odd half: hold the low word until its even partner
                    low_word_next = wdata_reg[WORD_W-1:0];
                    low_pend_next = 1'b1;
                    low_addr_next = addr_reg;
                end
                else if (low_pend_reg && low_addr_reg == b_idx)
                begin
                    if (ent_a[WORD_W-1:0] != wdata_reg[WORD_W-1:0])
                    begin
                        wr_a              = 1'b1;
                        new_a[WORD_W-1:0] = wdata_reg[WORD_W-1:0];
                        hcf_next[a_idx]   = 1'b1;
                    end
                    if (ent_b[WORD_W-1:0] != low_word_reg)
                    begin
                        wr_b              = 1'b1;
                        new_b[WORD_W-1:0] = low_word_reg;
                        hcf_next[b_idx]   = 1'b1;
                    end
                    low_pend_next    = 1'b0;
                    init_next[a_idx] = 1'b0;
                    init_next[b_idx] = 1'b0;
                end
                else
                begin
                    low_pend_next = 1'b0;
                    status        = ST_SEQ_ERR;
                end
            end
            CMD_WR_LONG:
            begin
                kind_long = 1'b1;
                if (long_ok && holding_mask_reg[a_idx])
                begin
                    if ({ent_a[WORD_W-1:0], ent_b[WORD_W-1:0]} != wdata_reg)
                    begin
                        wr_a              = 1'b1;
                        wr_b              = 1'b1;
                        new_a[WORD_W-1:0] = wdata_reg[31:WORD_W];
                        new_b[WORD_W-1:0] = wdata_reg[WORD_W-1:0];
                        hcf_next[a_idx]   = 1'b1;
                        hcf_next[b_idx]   = 1'b1;
                    end
                end
                else
                begin
                    status = ST_NOT_BOUND;
                end
            end
            CMD_RD_COIL:
            begin
                kind_coil = 1'b1;
                if (word_ok && coil_mask_reg[a_idx])
                begin
                    rd_data = {31'd0, ent_a[WORD_W]};
                end
                else
                begin
                    status = ST_NOT_BOUND;
                end
            end
            CMD_RD_WORD:
            begin
                kind_word = 1'b1;
                if (word_ok && holding_mask_reg[a_idx])
                begin
                    rd_data = {16'd0, ent_a[WORD_W-1:0]};
                end
                else
                begin
                    status = ST_NOT_BOUND;
                end
            end
            CMD_RD_LONG:
            begin
                kind_long = 1'b1;
                if (long_ok && holding_mask_reg[a_idx])
                begin
                    rd_data = {ent_a[WORD_W-1:0], ent_b[WORD_W-1:0]};
                end
                else
                begin
                    status = ST_NOT_BOUND;
                end
            end
            CMD_INIT_WORD:
            begin
                kind_word = 1'b1;
                if (word_ok)
                begin
                    init_next[a_idx] = 1'b1;
                end
                else
                begin
                    status = ST_NO_ADDR;
                end
            end
            CMD_INIT_LONG:
            begin
                kind_long = 1'b1;
                if (long_ok)
                begin
                    init_next[a_idx] = 1'b1;
                    init_next[b_idx] = 1'b1;
                end
                else
                begin
                    status = ST_NO_ADDR;
                end
            end
            CMD_CLEAR:
            begin
                ccf_next = '0;
                hcf_next = '0;
            end
            default:
            begin
                status = ST_NO_ADDR;
            end
        endcase

        if (wr_a)
        begin
            vld_next[a_idx] = 1'b1;
        end
        if (wr_b)
        begin
            vld_next[b_idx] = 1'b1;
        end

        // register flags after the access
        changed = 1'b0;
        inited  = 1'b1;
        if (word_ok)
        begin
            if (kind_coil)
            begin
                changed = ccf_next[a_idx];
            end
            else if (kind_word || kind_long)
            begin
                changed = hcf_next[a_idx] || (kind_long && long_ok && hcf_next[b_idx]);
                inited  = !init_next[a_idx];
            end
        end
        any_chg = |(ccf_next | hcf_next);

        m_data_next = {3'd0, 32'(init_next), any_chg, inited, changed, rd_data, status};

        // bank write steering: a and a+1 always land in different banks
        even_we    = addr_reg[0] ? wr_b : wr_a;
        odd_we     = addr_reg[0] ? wr_a : wr_b;
        even_wrow  = addr_reg[0] ? b_idx[ADDR_W-1:1] : a_idx[ADDR_W-1:1];
        odd_wrow   = a_idx[ADDR_W-1:1];
        even_wdata = addr_reg[0] ? new_b : new_a;
        odd_wdata  = addr_reg[0] ? new_a : new_b;
    end

    // banks: one read at accept, one write at execute
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            even_rd_reg <= even_mem[even_rrow];
            odd_rd_reg  <= odd_mem[odd_rrow];
        end
        if (exec_fire && even_we)
        begin
            even_mem[even_wrow] <= even_wdata;
        end
        if (exec_fire && odd_we)
        begin
            odd_mem[odd_wrow] <= odd_wdata;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg   <= s_tdata[CMD_W-1:0];
            addr_reg  <= in_addr;
            wdata_reg <= s_tdata[CMD_W+ADDR_W +: 32];
        end
        if (exec_fire)
        begin
            m_data_reg <= m_data_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            m_valid_reg      <= 1'b0;
            coil_mask_reg    <= '0;
            holding_mask_reg <= '0;
            vld_reg          <= '0;
            ccf_reg          <= '0;
            hcf_reg          <= '0;
            init_reg         <= '0;
            low_pend_reg     <= 1'b0;
            low_word_reg     <= '0;
            low_addr_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (exec_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            // bind masks
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COIL_MASK:    coil_mask_reg    <= cfg_wdata;
                    CFG_HOLDING_MASK: holding_mask_reg <= cfg_wdata;
                    default:          ;
                endcase
            end

            if (exec_fire)
            begin
                vld_reg      <= vld_next;
                ccf_reg      <= ccf_next;
                hcf_reg      <= hcf_next;
                init_reg     <= init_next;
                low_pend_reg <= low_pend_next;
                low_word_reg <= low_word_next;
                low_addr_reg <= low_addr_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

/* rtl/mbrf_checker.sv */
// port-level checker for the modbus register file and its bind
`default_nettype none
module mbrf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [mbrf_pkg::OUT_W-1:0] m_tdata
);
    import mbrf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one executes");

    // read data only on success
    a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:2] != 32'd0) |-> (m_tdata[1:0] == ST_OK))
        else $error("read data with failing status");

    // a changed register implies some change flag set
    a_chg_any: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> m_tdata[36])
        else $error("reg_changed without any_changed");

endmodule

bind modbus_register_file mbrf_checker u_mbrf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
